>>> design/pcrg_pkg.sv
package pcrg_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SCALE_W    = 24;
   localparam int COL_W      = 48;
   localparam int ENTRY_W    = 16;
   localparam int POS_W      = 32;
   localparam int DIR_W      = 16;
   localparam int MAG_W      = 41;
   localparam int UNIT_W     = 30;
   localparam int SUM_W      = 62;
   localparam int ROOT_W     = 31;
   localparam int DIVIDEND_W = 45;
   localparam int QUO_W      = 15;
   localparam int FRAC_Q14   = 14;

   localparam int FRONT_STAGES = 10;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 15;
   localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + 1 + DIV_STEPS + 1;

   typedef enum logic [2:0] {
      REG_ROT_COL_X      = 3'd0,
      REG_ROT_COL_Y      = 3'd1,
      REG_ROT_COL_Z      = 3'd2,
      REG_CAM_POS_X      = 3'd3,
      REG_CAM_POS_Y      = 3'd4,
      REG_CAM_POS_Z      = 3'd5,
      REG_SENSOR_SCALE_X = 3'd6,
      REG_SENSOR_SCALE_Y = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] origin_x;
      logic [POS_W-1:0] origin_y;
      logic [POS_W-1:0] origin_z;
      logic [2:0]       dir_neg;
      logic             dir_zero;
   } side_type;

endpackage

>>> design/pinhole_camera_ray_generation.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_stall    req_sample_x, req_sample_y
// rsp      out        rsp_valid/rsp_stall    rsp_origin_{x,y,z}, rsp_dir_{x,y,z}
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One sample enters per cycle unless the output stalls; rays leave in sample order.
// Most of the latency comes from the 32-step square root and 15-step divider chains.
// Reset is synchronous; it clears the valid bits and loads register defaults.
// A stalled output beat freezes the whole pipeline and stalls the input.
module pinhole_camera_ray_generation import pcrg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_W-1:0]        req_sample_x,
   input  logic [SAMPLE_W-1:0]        req_sample_y,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [POS_W-1:0]    rsp_origin_x,
   output logic signed [POS_W-1:0]    rsp_origin_y,
   output logic signed [POS_W-1:0]    rsp_origin_z,
   output logic signed [DIR_W-1:0]    rsp_dir_x,
   output logic signed [DIR_W-1:0]    rsp_dir_y,
   output logic signed [DIR_W-1:0]    rsp_dir_z,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [COL_W-1:0]           csr_data
);

   logic [COL_W-1:0]   rot_col_x_ff, rot_col_y_ff, rot_col_z_ff;
   logic [POS_W-1:0]   cam_pos_x_ff, cam_pos_y_ff, cam_pos_z_ff;
   logic [SCALE_W-1:0] scale_x_ff, scale_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_col_x_ff <= COL_W'(48'h0000_0000_4000);
         rot_col_y_ff <= COL_W'(48'h0000_4000_0000);
         rot_col_z_ff <= COL_W'(48'h4000_0000_0000);
         cam_pos_x_ff <= '0;
         cam_pos_y_ff <= '0;
         cam_pos_z_ff <= '0;
         scale_x_ff   <= SCALE_W'(24'd131072);
         scale_y_ff   <= SCALE_W'(24'd131072);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_ROT_COL_X:      rot_col_x_ff <= csr_data;
            REG_ROT_COL_Y:      rot_col_y_ff <= csr_data;
            REG_ROT_COL_Z:      rot_col_z_ff <= csr_data;
            REG_CAM_POS_X:      cam_pos_x_ff <= csr_data[POS_W-1:0];
            REG_CAM_POS_Y:      cam_pos_y_ff <= csr_data[POS_W-1:0];
            REG_CAM_POS_Z:      cam_pos_z_ff <= csr_data[POS_W-1:0];
            REG_SENSOR_SCALE_X: scale_x_ff   <= csr_data[SCALE_W-1:0];
            REG_SENSOR_SCALE_Y: scale_y_ff   <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   logic              enable;
   logic [LATENCY:1]  vld_ff;

   assign enable    = !(vld_ff[LATENCY] && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = vld_ff[LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[LATENCY-1:1], req_valid};
      end
   end

   // sensor offsets
   logic [16:0]        dx, dy;
   logic signed [41:0] prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;

   always_comb begin
      dx = 17'd32768 - {1'b0, req_sample_x};
      dy = 17'd32768 - {1'b0, req_sample_y};
      prod_x_in = $signed(dx) * $signed({1'b0, scale_x_ff});
      prod_y_in = $signed(dy) * $signed({1'b0, scale_y_ff});
   end

   logic [41:0]        mag_px, mag_py;
   logic [25:0]        rnd_px, rnd_py;
   logic signed [24:0] sx_in, sy_in, sx_ff, sy_ff;

   always_comb begin
      mag_px = prod_x_ff[41] ? 42'(-prod_x_ff) : 42'(prod_x_ff);
      mag_py = prod_y_ff[41] ? 42'(-prod_y_ff) : 42'(prod_y_ff);
      rnd_px = 26'((mag_px + 42'd32768) >> 16);
      rnd_py = 26'((mag_py + 42'd32768) >> 16);
      sx_in  = prod_x_ff[41] ? 25'(-rnd_px) : 25'(rnd_px);
      sy_in  = prod_y_ff[41] ? 25'(-rnd_py) : 25'(rnd_py);
   end

   // rotation
   logic signed [40:0] pa_in [3], pb_in [3], pa_ff [3], pb_ff [3];
   logic signed [41:0] vec_in [3], vec_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa_in[k] = $signed(rot_col_x_ff[ENTRY_W*k +: ENTRY_W]) * sx_ff;
         pb_in[k] = $signed(rot_col_y_ff[ENTRY_W*k +: ENTRY_W]) * sy_ff;
         vec_in[k] = 42'(pa_ff[k]) + 42'(pb_ff[k]) +
                     $signed({{10{rot_col_z_ff[ENTRY_W*k+ENTRY_W-1]}},
                              rot_col_z_ff[ENTRY_W*k +: ENTRY_W], 16'd0});
      end
   end

   // origin and magnitudes
   logic [POS_W-1:0] pos [3];
   logic [41:0]      mag_v [3];
   logic [27:0]      rnd_v [3];
   logic [32:0]      sum_o [3];
   logic [POS_W-1:0] org_in [3];
   logic [MAG_W-1:0] mag5_in [3];
   side_type         side5_in, side5_ff;
   logic [MAG_W-1:0] mag5_ff [3];

   assign pos[0] = cam_pos_x_ff;
   assign pos[1] = cam_pos_y_ff;
   assign pos[2] = cam_pos_z_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag_v[k] = vec_ff[k][41] ? 42'(-vec_ff[k]) : 42'(vec_ff[k]);
         rnd_v[k] = 28'((mag_v[k] + 42'd8192) >> FRAC_Q14);
         sum_o[k] = (vec_ff[k][41] ? 33'(-{5'd0, rnd_v[k]}) : {5'd0, rnd_v[k]}) +
                    {pos[k][POS_W-1], pos[k]};
         case (sum_o[k][32:31])
            2'b01:   org_in[k] = 32'h7FFF_FFFF;
            2'b10:   org_in[k] = 32'h8000_0000;
            default: org_in[k] = sum_o[k][31:0];
         endcase
         mag5_in[k] = mag_v[k][MAG_W-1:0];
      end
      side5_in.origin_x = org_in[0];
      side5_in.origin_y = org_in[1];
      side5_in.origin_z = org_in[2];
      for (int k = 0; k < 3; k++) begin
         side5_in.dir_neg[k] = !vec_ff[k][41] && (vec_ff[k] != 42'sd0);
      end
      side5_in.dir_zero = (vec_ff[0] == 42'sd0) && (vec_ff[1] == 42'sd0) &&
                          (vec_ff[2] == 42'sd0);
   end

   // normalize
   logic [MAG_W-1:0]  max6_in, max6_ff;
   logic [MAG_W-1:0]  mag6_ff [3];
   side_type          side6_ff;
   logic [5:0]        lead7_in, lead7_ff;
   logic [MAG_W-1:0]  mag7_ff [3];
   side_type          side7_ff;
   logic [UNIT_W-1:0] unit8_in [3], unit8_ff [3];
   side_type          side8_ff;

   always_comb begin
      max6_in = (mag5_ff[0] > mag5_ff[1]) ? mag5_ff[0] : mag5_ff[1];
      if (mag5_ff[2] > max6_in) begin
         max6_in = mag5_ff[2];
      end
      lead7_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (max6_ff[i]) begin
            lead7_in = 6'(i);
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (lead7_ff >= 6'(UNIT_W - 1)) begin
            unit8_in[k] = UNIT_W'(mag7_ff[k] >> (lead7_ff - 6'(UNIT_W - 1)));
         end else begin
            unit8_in[k] = UNIT_W'(mag7_ff[k] << (6'(UNIT_W - 1) - lead7_ff));
         end
      end
   end

   // squares and sum
   logic [59:0]       sq9_in [3], sq9_ff [3];
   logic [UNIT_W-1:0] unit9_ff [3], unit10_ff [3];
   side_type          side9_ff, side10_ff;
   logic [SUM_W-1:0]  sum10_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq9_in[k] = unit8_ff[k] * unit8_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         vec_ff    <= vec_in;
         mag5_ff   <= mag5_in;
         side5_ff  <= side5_in;
         max6_ff   <= max6_in;
         mag6_ff   <= mag5_ff;
         side6_ff  <= side5_ff;
         lead7_ff  <= lead7_in;
         mag7_ff   <= mag6_ff;
         side7_ff  <= side6_ff;
         unit8_ff  <= unit8_in;
         side8_ff  <= side7_ff;
         sq9_ff    <= sq9_in;
         unit9_ff  <= unit8_ff;
         side9_ff  <= side8_ff;
         sum10_ff  <= SUM_W'(sq9_ff[0]) + SUM_W'(sq9_ff[1]) + SUM_W'(sq9_ff[2]);
         unit10_ff <= unit9_ff;
         side10_ff <= side9_ff;
      end
   end

   // square root
   logic [ROOT_W-1:0] root;
   side_type          side_sq_ff [SQRT_STEPS];
   logic [UNIT_W-1:0] unit_sq_ff [SQRT_STEPS][3];

   pcrg_sqrt u_sqrt (
      .clock    (clock),
      .enable   (enable),
      .radicand (sum10_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         side_sq_ff[0] <= side10_ff;
         unit_sq_ff[0] <= unit10_ff;
         for (int i = 1; i < SQRT_STEPS; i++) begin
            side_sq_ff[i] <= side_sq_ff[i-1];
            unit_sq_ff[i] <= unit_sq_ff[i-1];
         end
      end
   end

   // dividend setup
   logic [DIVIDEND_W-1:0] num_ff [3];
   logic [ROOT_W-1:0]     root_ff;
   side_type              side_nm_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= DIVIDEND_W'({unit_sq_ff[SQRT_STEPS-1][k], 14'd0}) +
                         DIVIDEND_W'(root >> 1);
         end
         root_ff    <= root;
         side_nm_ff <= side_sq_ff[SQRT_STEPS-1];
      end
   end

   // division
   logic [QUO_W-1:0] quo [3];
   side_type         side_dv_ff [DIV_STEPS];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      pcrg_div u_div (
         .clock    (clock),
         .enable   (enable),
         .dividend (num_ff[k]),
         .divisor  (root_ff),
         .quotient (quo[k])
      );
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_dv_ff[0] <= side_nm_ff;
         for (int i = 1; i < DIV_STEPS; i++) begin
            side_dv_ff[i] <= side_dv_ff[i-1];
         end
      end
   end

   // output beat
   side_type         side_out;
   logic [DIR_W-1:0] dir_in [3];
   logic [DIR_W-1:0] dir_ff [3];
   logic [POS_W-1:0] org_out_ff [3];

   assign side_out = side_dv_ff[DIV_STEPS-1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (side_out.dir_zero) begin
            dir_in[k] = '0;
         end else if (side_out.dir_neg[k]) begin
            dir_in[k] = DIR_W'(-{1'b0, quo[k]});
         end else begin
            dir_in[k] = DIR_W'({1'b0, quo[k]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dir_ff        <= dir_in;
         org_out_ff[0] <= side_out.origin_x;
         org_out_ff[1] <= side_out.origin_y;
         org_out_ff[2] <= side_out.origin_z;
      end
   end

   assign rsp_origin_x = $signed(org_out_ff[0]);
   assign rsp_origin_y = $signed(org_out_ff[1]);
   assign rsp_origin_z = $signed(org_out_ff[2]);
   assign rsp_dir_x    = $signed(dir_ff[0]);
   assign rsp_dir_y    = $signed(dir_ff[1]);
   assign rsp_dir_z    = $signed(dir_ff[2]);

   a_freeze_on_stall: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(vld_ff))
      else $error("valid line moved during stall");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dir_x <= 16'sd16384 && rsp_dir_x >= -16'sd16384 &&
                     rsp_dir_y <= 16'sd16384 && rsp_dir_y >= -16'sd16384 &&
                     rsp_dir_z <= 16'sd16384 && rsp_dir_z >= -16'sd16384))
      else $error("direction component out of unit range");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no output beat waiting");

endmodule

>>> design/pcrg_sqrt.sv
module pcrg_sqrt import pcrg_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [SUM_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [63:0] x_ff   [1:SQRT_STEPS];
   logic [63:0] res_ff [1:SQRT_STEPS];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic [63:0] x_cur;
      logic [63:0] res_cur;
      logic [63:0] trial;
      logic [63:0] x_in;
      logic [63:0] res_in;

      if (i == 0) begin : g_first
         assign x_cur   = 64'(radicand);
         assign res_cur = 64'd0;
      end else begin : g_rest
         assign x_cur   = x_ff[i];
         assign res_cur = res_ff[i];
      end

      always_comb begin
         trial = res_cur + BIT;
         if (x_cur >= trial) begin
            x_in   = x_cur - trial;
            res_in = (res_cur >> 1) + BIT;
         end else begin
            x_in   = x_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i+1]   <= x_in;
            res_ff[i+1] <= res_in;
         end
      end
   end

   assign root = res_ff[SQRT_STEPS][ROOT_W-1:0];

endmodule

>>> design/pcrg_div.sv
module pcrg_div import pcrg_pkg::*; (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [ROOT_W-1:0]     divisor,
   output logic [QUO_W-1:0]      quotient
);

   logic [DIVIDEND_W:0] rem_ff [1:DIV_STEPS];
   logic [ROOT_W-1:0]   dvs_ff [1:DIV_STEPS];
   logic [QUO_W-1:0]    quo_ff [1:DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      localparam int J = DIV_STEPS - 1 - i;
      logic [DIVIDEND_W:0] rem_cur;
      logic [ROOT_W-1:0]   dvs_cur;
      logic [QUO_W-1:0]    quo_cur;
      logic [DIVIDEND_W:0] trial;
      logic [DIVIDEND_W:0] rem_in;
      logic [QUO_W-1:0]    quo_in;

      if (i == 0) begin : g_first
         assign rem_cur = (DIVIDEND_W+1)'(dividend);
         assign dvs_cur = divisor;
         assign quo_cur = '0;
      end else begin : g_rest
         assign rem_cur = rem_ff[i];
         assign dvs_cur = dvs_ff[i];
         assign quo_cur = quo_ff[i];
      end

      always_comb begin
         trial = (DIVIDEND_W+1)'(dvs_cur) << J;
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            quo_in = quo_cur | (QUO_W'(1) << J);
         end else begin
            rem_in = rem_cur;
            quo_in = quo_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i+1] <= rem_in;
            dvs_ff[i+1] <= dvs_cur;
            quo_ff[i+1] <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[DIV_STEPS];

endmodule
